/* sv/adam_pkg.sv */
// ----------------------------------------------------------------------------
// adam_pkg
// Shared types and constants of the Adam update engine.
// ----------------------------------------------------------------------------
`default_nettype none

package adam_pkg;

  localparam int DataW       = 32;
  localparam int IdxW        = 10;
  localparam int CfgW        = 24;
  localparam int CfgIdxW     = 2;
  localparam int PowW        = 25;
  localparam int NumParamsDef = 1024;

  localparam logic [PowW-1:0] OneQ24 = 25'h1000000;

  localparam logic [23:0] LrReset  = 24'd16777;
  localparam logic [23:0] B1Reset  = 24'd15099494;
  localparam logic [23:0] B2Reset  = 24'd16760439;
  localparam logic [15:0] EpsReset = 16'd1;

  localparam int DvdW = 64;
  localparam int DvsW = 42;
  localparam int QuoW = 48;
  localparam int CntW = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LR  = 2'd0,
    CFG_B1  = 2'd1,
    CFG_B2  = 2'd2,
    CFG_EPS = 2'd3
  } cfg_idx_e;

  typedef enum logic [0:0] {
    REQ_LOAD = 1'b0,
    REQ_GRAD = 1'b1
  } req_type_e;

  typedef struct packed {
    logic            start;
    logic            sqrt_mode;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
    logic [CntW-1:0] qbits;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic            overflow;
    logic [QuoW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* sv/adam_ram.sv */
// ----------------------------------------------------------------------------
// adam_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

/* sv/adam_divsqrt.sv */
// ----------------------------------------------------------------------------
// adam_divsqrt
// Shared shift-subtract unit: restoring division or integer square root,
// one quotient or root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_divsqrt (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire adam_pkg::div_req_t  req_i,
  output adam_pkg::div_rsp_t       rsp_o
);

  import adam_pkg::*;

  localparam int RemW = 44;

  logic            busy_q, done_q, ovf_q, mode_q;
  logic [RemW-1:0] rem_q;
  logic [DvdW-1:0] lo_q;
  logic [QuoW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic [DvsW-1:0] dvs_q;

  logic [DvdW-1:0] hi_init, lo_init;
  logic [RemW-1:0] shifted, trial;
  logic            ge;

  always_comb begin
    hi_init = req_i.dividend >> req_i.qbits;
    lo_init = req_i.dividend << (7'd64 - {1'b0, req_i.qbits});
    if (mode_q) begin
      shifted = {rem_q[RemW-3:0], lo_q[DvdW-1 -: 2]};
      trial   = RemW'({quo_q[31:0], 2'b01});
    end else begin
      shifted = {rem_q[RemW-2:0], lo_q[DvdW-1]};
      trial   = RemW'(dvs_q);
    end
    ge = (shifted >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == CntW'(1))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.sqrt_mode;
      dvs_q  <= req_i.divisor;
      cnt_q  <= req_i.qbits;
      quo_q  <= '0;
      if (req_i.sqrt_mode) begin
        rem_q <= '0;
        lo_q  <= req_i.dividend;
        ovf_q <= 1'b0;
      end else begin
        rem_q <= hi_init[RemW-1:0];
        lo_q  <= lo_init;
        ovf_q <= (hi_init >= DvdW'(req_i.divisor));
      end
    end else if (busy_q) begin
      rem_q <= ge ? (shifted - trial) : shifted;
      quo_q <= {quo_q[QuoW-2:0], ge};
      lo_q  <= mode_q ? {lo_q[DvdW-3:0], 2'b00} : {lo_q[DvdW-2:0], 1'b0};
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.overflow = ovf_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

/* sv/adam_optimizer_update.sv */
// ----------------------------------------------------------------------------
// adam_optimizer_update
// Per-parameter Adam update engine in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One beat at a time: a load beat or an out-of-range index goes straight to
// the done state. A gradient beat also updates the bias-correction powers
// when it closes an epoch and skips each bias correction whose factor is
// zero. The gradient time is set by the single shared shift-subtract unit,
// which produces one bit per cycle for the first-moment correction (32), the
// second-moment correction (48), the square root (32) and the step division
// (34), plus a 33x33 multiplier that forms eight products over the sequencer
// steps. A finished result waits in the output register while the next beat
// is taken. The parameter stores need no clearing after reset.
`default_nettype none

module adam_optimizer_update #(
  parameter int NUM_PARAMS = adam_pkg::NumParamsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [adam_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [adam_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         req_type_i,
  input  wire logic [adam_pkg::IdxW-1:0]    param_index_i,
  input  wire logic signed [adam_pkg::DataW-1:0] data_value_i,
  input  wire logic                         last_of_epoch_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [adam_pkg::IdxW-1:0]         out_index_o,
  output logic signed [adam_pkg::DataW-1:0] new_weight_o,
  output logic                              saturated_o
);

  import adam_pkg::*;

  localparam int AddrW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_READ  = 19'h00002,
    S_MG1   = 19'h00004,
    S_MSQ   = 19'h00008,
    S_MB2   = 19'h00010,
    S_MG2   = 19'h00020,
    S_MVN   = 19'h00040,
    S_MH_GO = 19'h00080,
    S_MH_WT = 19'h00100,
    S_VH_GO = 19'h00200,
    S_VH_WT = 19'h00400,
    S_SQ_GO = 19'h00800,
    S_SQ_WT = 19'h01000,
    S_ST_GO = 19'h02000,
    S_ST_WT = 19'h04000,
    S_PW1   = 19'h08000,
    S_PW2   = 19'h10000,
    S_PW3   = 19'h20000,
    S_DONE  = 19'h40000
  } state_e;

  state_e state_q, state_d;

  logic [23:0]     lr_q, b1_q, b2_q;
  logic [15:0]     eps_q;
  logic [PowW-1:0] fp_q, sp_q;

  logic                    out_valid_q, saturated_q;
  logic [IdxW-1:0]         out_index_q;
  logic signed [DataW-1:0] new_weight_q;

  logic [IdxW-1:0]         idx_q;
  logic                    last_q, sat_q;
  logic signed [DataW-1:0] g_q, w_q, mn_q, mhat_q, res_w_q;
  logic [DataW-1:0]        v_q, g2_q, vn_q;
  logic [47:0]             vhat_q;
  logic [32:0]             denom_q;
  logic signed [65:0]      prod_q, acc_q;

  logic              in_acc, in_range, out_free;
  logic [AddrW-1:0]  addr;
  logic              w_we, m_we, v_we;
  logic [DataW-1:0]  w_wd, m_wd, v_wd, w_rd, m_rd, v_rd;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_d, sum, sum_b;
  logic [DataW-1:0]   ga, mhat_mag, mn_mag, vn_d, q_mag;
  logic [PowW-1:0]    c1, c2;
  logic [33:0]        step;
  logic signed [36:0] wdiff;
  logic [32:0]        root_eps;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_range = ({22'd0, param_index_i} < 32'(NUM_PARAMS));
  assign out_free = !out_valid_q || !out_stall_i;
  assign addr     = (state_q == S_IDLE) ? AddrW'(param_index_i) : AddrW'(idx_q);

  assign ga       = g_q[DataW-1] ? DataW'(-g_q) : DataW'(g_q);
  assign mhat_mag = mhat_q[DataW-1] ? DataW'(-mhat_q) : DataW'(mhat_q);
  assign mn_mag   = mn_q[DataW-1] ? DataW'(-mn_q) : DataW'(mn_q);
  assign c1       = OneQ24 - ((fp_q > OneQ24) ? OneQ24 : fp_q);
  assign c2       = OneQ24 - ((sp_q > OneQ24) ? OneQ24 : sp_q);
  assign sum      = acc_q + prod_q;
  assign sum_b    = sum + (sum[65] ? 66'sd16777215 : 66'sd0);
  assign vn_d     = sum[55:24];
  assign prod_d   = mul_a * mul_b;
  assign q_mag    = div_rsp.quotient[DataW-1:0];
  assign root_eps = {1'b0, div_rsp.quotient[31:0]} + {17'd0, eps_q};
  assign step     = div_rsp.overflow ? '1 : div_rsp.quotient[33:0];
  assign wdiff    = mhat_q[DataW-1] ? (37'(w_q) + $signed({3'b000, step}))
                                    : (37'(w_q) - $signed({3'b000, step}));

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q) inside
      S_READ: begin
        mul_a = $signed({9'd0, b1_q});
        mul_b = $signed({m_rd[DataW-1], m_rd});
      end
      S_MG1: begin
        mul_a = $signed({8'd0, OneQ24 - {1'b0, b1_q}});
        mul_b = $signed({g_q[DataW-1], g_q});
      end
      S_MSQ: begin
        mul_a = $signed({1'b0, ga});
        mul_b = $signed({1'b0, ga});
      end
      S_MB2: begin
        mul_a = $signed({9'd0, b2_q});
        mul_b = $signed({1'b0, v_q});
      end
      S_MG2: begin
        mul_a = $signed({8'd0, OneQ24 - {1'b0, b2_q}});
        mul_b = $signed({1'b0, g2_q});
      end
      S_SQ_GO, S_SQ_WT, S_ST_GO: begin
        mul_a = $signed({1'b0, mhat_mag});
        mul_b = $signed({9'd0, lr_q});
      end
      S_PW1: begin
        mul_a = $signed({8'd0, fp_q});
        mul_b = $signed({9'd0, b1_q});
      end
      S_PW2: begin
        mul_a = $signed({8'd0, sp_q});
        mul_b = $signed({9'd0, b2_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    div_req = '0;
    w_we = 1'b0;
    m_we = 1'b0;
    v_we = 1'b0;
    w_wd = DataW'(data_value_i);
    m_wd = '0;
    v_wd = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_range && (req_type_i == REQ_LOAD)) begin
            w_we = 1'b1;
            m_we = 1'b1;
            v_we = 1'b1;
            state_d = S_DONE;
          end else if (in_range) begin
            state_d = S_READ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_READ:  state_d = S_MG1;
      S_MG1:   state_d = S_MSQ;
      S_MSQ:   state_d = S_MB2;
      S_MB2:   state_d = S_MG2;
      S_MG2:   state_d = S_MVN;
      S_MVN: begin
        m_we = 1'b1;
        m_wd = mn_q;
        v_we = 1'b1;
        v_wd = vn_d;
        state_d = S_MH_GO;
      end
      S_MH_GO: begin
        if (c1 == '0) begin
          state_d = S_VH_GO;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {8'd0, mn_mag, 24'd0};
          div_req.divisor  = DvsW'(c1);
          div_req.qbits    = CntW'(32);
          state_d = S_MH_WT;
        end
      end
      S_MH_WT: if (div_rsp.done) state_d = S_VH_GO;
      S_VH_GO: begin
        if (c2 == '0) begin
          state_d = S_SQ_GO;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {8'd0, vn_q, 24'd0};
          div_req.divisor  = DvsW'(c2);
          div_req.qbits    = CntW'(48);
          state_d = S_VH_WT;
        end
      end
      S_VH_WT: if (div_rsp.done) state_d = S_SQ_GO;
      S_SQ_GO: begin
        div_req.start     = 1'b1;
        div_req.sqrt_mode = 1'b1;
        div_req.dividend  = {vhat_q, 16'd0};
        div_req.qbits     = CntW'(32);
        state_d = S_SQ_WT;
      end
      S_SQ_WT: if (div_rsp.done) state_d = S_ST_GO;
      S_ST_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DvdW'(prod_q[55:0]);
        div_req.divisor  = {1'b0, denom_q, 8'd0};
        div_req.qbits    = CntW'(34);
        state_d = S_ST_WT;
      end
      S_ST_WT: begin
        if (div_rsp.done) begin
          w_we = 1'b1;
          if (wdiff > 37'sd2147483647) begin
            w_wd = 32'h7fffffff;
          end else if (wdiff < -37'sd2147483648) begin
            w_wd = 32'h80000000;
          end else begin
            w_wd = wdiff[DataW-1:0];
          end
          state_d = last_q ? S_PW1 : S_DONE;
        end
      end
      S_PW1:   state_d = S_PW2;
      S_PW2:   state_d = S_PW3;
      S_PW3:   state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lr_q        <= LrReset;
      b1_q        <= B1Reset;
      b2_q        <= B2Reset;
      eps_q       <= EpsReset;
      fp_q        <= OneQ24;
      sp_q        <= OneQ24;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_LR:  lr_q  <= cfg_data_i;
          CFG_B1:  b1_q  <= cfg_data_i;
          CFG_B2:  b2_q  <= cfg_data_i;
          CFG_EPS: eps_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == S_IDLE && in_acc && in_range && req_type_i == REQ_LOAD) begin
        fp_q <= {1'b0, b1_q};
        sp_q <= {1'b0, b2_q};
      end
      if (state_q == S_PW2) fp_q <= prod_q[48:24];
      if (state_q == S_PW3) sp_q <= prod_q[48:24];
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      S_IDLE: begin
        idx_q   <= param_index_i;
        g_q     <= data_value_i;
        last_q  <= last_of_epoch_i;
        sat_q   <= 1'b0;
        res_w_q <= (in_range && req_type_i == REQ_LOAD) ? data_value_i : '0;
      end
      S_READ: begin
        v_q <= v_rd;
        w_q <= w_rd;
      end
      S_MG1: acc_q <= prod_q;
      S_MSQ: mn_q  <= sum_b[55:24];
      S_MB2: begin
        if (prod_q[65:48] != '0) begin
          g2_q  <= '1;
          sat_q <= 1'b1;
        end else begin
          g2_q <= prod_q[47:16];
        end
      end
      S_MG2: acc_q <= prod_q;
      S_MVN: vn_q  <= vn_d;
      S_MH_GO: if (c1 == '0) mhat_q <= mn_q;
      S_MH_WT: begin
        if (div_rsp.done) begin
          if (mn_q[DataW-1]) begin
            if (div_rsp.overflow || q_mag > 32'h80000000) begin
              mhat_q <= 32'sh80000000;
              sat_q  <= 1'b1;
            end else begin
              mhat_q <= -$signed(q_mag);
            end
          end else begin
            if (div_rsp.overflow || q_mag > 32'h7fffffff) begin
              mhat_q <= 32'sh7fffffff;
              sat_q  <= 1'b1;
            end else begin
              mhat_q <= $signed(q_mag);
            end
          end
        end
      end
      S_VH_GO: if (c2 == '0) vhat_q <= {16'd0, vn_q};
      S_VH_WT: begin
        if (div_rsp.done) begin
          if (div_rsp.overflow) begin
            vhat_q <= '1;
            sat_q  <= 1'b1;
          end else begin
            vhat_q <= div_rsp.quotient;
          end
        end
      end
      S_SQ_WT: if (div_rsp.done) denom_q <= (root_eps == '0) ? 33'd1 : root_eps;
      S_ST_WT: begin
        if (div_rsp.done) begin
          res_w_q <= w_wd;
          if (wdiff > 37'sd2147483647 || wdiff < -37'sd2147483648) sat_q <= 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q == S_DONE && out_free) begin
      out_index_q  <= idx_q;
      new_weight_q <= res_w_q;
      saturated_q  <= sat_q;
    end
  end

  adam_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  adam_ram #(.Width(DataW), .Depth(NUM_PARAMS), .AddrW(AddrW)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .addr_i  (addr),
    .wdata_i (w_wd),
    .rdata_o (w_rd)
  );

  adam_ram #(.Width(DataW), .Depth(NUM_PARAMS), .AddrW(AddrW)) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .addr_i  (addr),
    .wdata_i (m_wd),
    .rdata_o (m_rd)
  );

  adam_ram #(.Width(DataW), .Depth(NUM_PARAMS), .AddrW(AddrW)) u_sq_mean_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .addr_i  (addr),
    .wdata_i (v_wd),
    .rdata_o (v_rd)
  );

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_index_q;
  assign new_weight_o = new_weight_q;
  assign saturated_o  = saturated_q;

endmodule

`default_nettype wire
